[rtl/core/invc_pkg.sv]
// invc_pkg: shared constants and the beat token type of the inversion counter
// no dependencies

package invc_pkg;

    localparam int MAX_ELEMENTS = 1024;

    localparam int VALUE_W = 32;
    localparam int IDX_W   = $clog2(MAX_ELEMENTS);
    localparam int CNT_W   = $clog2(MAX_ELEMENTS);
    localparam int FILL_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int TOTAL_W = 19;

    localparam logic [FILL_W-1:0]  FILL_FULL = FILL_W'(MAX_ELEMENTS);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam int OUT_DATA_W = ((TOTAL_W + 1 + 7) / 8) * 8;

    // one element travelling down the cell row
    typedef struct packed {
        logic                      vld;
        logic                      last;
        logic                      drop;
        logic [IDX_W-1:0]          idx;
        logic [CNT_W-1:0]          cnt;
        logic signed [VALUE_W-1:0] value;
    } invc_tok_t;

endpackage

[rtl/core/invc_cell.sv]
// invc_cell: one stored element, compares each passing token against it
// depends on invc_pkg

module invc_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic [invc_pkg::IDX_W-1:0] cell_idx,
    input  invc_pkg::invc_tok_t       tok_in,
    output invc_pkg::invc_tok_t       tok_out
);
    import invc_pkg::*;

    logic signed [VALUE_W-1:0] stored_reg;
    logic signed [VALUE_W-1:0] stored_next;
    invc_tok_t                 tok_reg;
    invc_tok_t                 tok_next;
    logic                      hit;
    logic                      wr;

    // only cells written earlier in this array take part
    assign hit = tok_in.vld && !tok_in.drop && (cell_idx < tok_in.idx)
                 && (stored_reg > tok_in.value);
    assign wr  = tok_in.vld && !tok_in.drop && (cell_idx == tok_in.idx);

    always_comb
    begin
        tok_next    = tok_in;
        stored_next = stored_reg;
        if (hit)
        begin
            tok_next.cnt = tok_in.cnt + CNT_W'(1);
        end
        if (wr)
        begin
            stored_next = tok_in.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else if (adv)
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stored_reg <= stored_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

[rtl/core/invc_chain.sv]
// invc_chain: the row of cells, one per storable element
// depends on invc_pkg and invc_cell

module invc_chain (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  invc_pkg::invc_tok_t tok_in,
    output invc_pkg::invc_tok_t tok_out
);
    import invc_pkg::*;

    invc_tok_t tok_tap [0:MAX_ELEMENTS];

    assign tok_tap[0] = tok_in;

    genvar g;
    generate
        for (g = 0; g < MAX_ELEMENTS; g++)
        begin : g_cell
            invc_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .adv      (adv),
                .cell_idx (IDX_W'(g)),
                .tok_in   (tok_tap[g]),
                .tok_out  (tok_tap[g+1])
            );
        end
    endgenerate

    assign tok_out = tok_tap[MAX_ELEMENTS];

endmodule

[rtl/core/invc_tail.sv]
// invc_tail: sums per-element counts, holds the result beat
// depends on invc_pkg

module invc_tail (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  invc_pkg::invc_tok_t             tok_in,
    output logic                            res_valid,
    output logic [invc_pkg::TOTAL_W-1:0]    res_total,
    output logic                            res_exceeded,
    input  logic                            res_taken
);
    import invc_pkg::*;

    logic [TOTAL_W-1:0] total_reg;
    logic [TOTAL_W-1:0] total_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic               res_valid_reg;
    logic               res_valid_next;
    logic [TOTAL_W-1:0] res_total_reg;
    logic [TOTAL_W-1:0] res_total_next;
    logic               res_exc_reg;
    logic               res_exc_next;
    logic [TOTAL_W:0]   sum;
    logic [TOTAL_W-1:0] sat_sum;

    assign sum     = {1'b0, total_reg} + (TOTAL_W + 1)'(tok_in.cnt);
    assign sat_sum = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

    always_comb
    begin
        total_next     = total_reg;
        ovf_next       = ovf_reg;
        res_valid_next = res_valid_reg && !res_taken;
        res_total_next = res_total_reg;
        res_exc_next   = res_exc_reg;
        if (adv && tok_in.vld)
        begin
            if (tok_in.last)
            begin
                res_valid_next = 1'b1;
                res_total_next = sat_sum;
                res_exc_next   = ovf_reg || tok_in.drop;
                total_next     = '0;
                ovf_next       = 1'b0;
            end
            else
            begin
                total_next = sat_sum;
                ovf_next   = ovf_reg || tok_in.drop;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            total_reg     <= total_next;
            ovf_reg       <= ovf_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_total_reg <= res_total_next;
        res_exc_reg   <= res_exc_next;
    end

    assign res_valid    = res_valid_reg;
    assign res_total    = res_total_reg;
    assign res_exceeded = res_exc_reg;

endmodule

[rtl/core/inversion_counter_unit.sv]
// inversion_counter_unit: streaming inversion count over signed 32-bit arrays
// a result beat shows once the last element has passed the head register, each cell and the tail result register
// throughput: one element per cycle, set by the row of cells advancing one step a cycle
// the whole row stalls only while a result beat waits and the sink holds tready low
// reset (rst_n, async, active low) clears fill count, running total, overflow and result-valid flags and token valids
// stored element registers are not reset; a cell is read only after it is written

module inversion_counter_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    // slave side: tdata[31:0] element_value; tlast is_last
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [31:0]                     s_axis_tdata,
    input  logic                            s_axis_tlast,
    // master side: tdata[18:0] inversion_total, [19] capacity_exceeded, rest zero
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [invc_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import invc_pkg::*;

    logic               adv;
    logic               s_beat;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    invc_tok_t          head_reg;
    invc_tok_t          head_next;
    invc_tok_t          tail_tok;
    logic               res_valid;
    logic [TOTAL_W-1:0] res_total;
    logic               res_exceeded;

    // the row moves whenever the result slot is free or being emptied
    assign adv           = !res_valid || m_axis_tready;
    assign s_axis_tready = adv;
    assign s_beat        = s_axis_tvalid && s_axis_tready;

    // head: give each element its slot index, or mark it dropped once full
    always_comb
    begin
        fill_next      = fill_reg;
        head_next      = '0;
        head_next.last = s_axis_tlast;
        head_next.value = $signed(s_axis_tdata);
        if (s_beat)
        begin
            head_next.vld = 1'b1;
            if (fill_reg == FILL_FULL)
            begin
                head_next.drop = 1'b1;
            end
            else
            begin
                head_next.idx = fill_reg[IDX_W-1:0];
                fill_next     = fill_reg + FILL_W'(1);
            end
            // next array starts from an empty row
            if (s_axis_tlast)
            begin
                fill_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            head_reg <= '0;
        end
        else if (adv)
        begin
            fill_reg <= fill_next;
            head_reg <= head_next;
        end
    end

    // each cell holds one element; tokens count greater stored values on the way
    invc_chain u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .tok_in  (head_reg),
        .tok_out (tail_tok)
    );

    // tail: per-array sum with saturation and the result register
    invc_tail u_tail (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .tok_in       (tail_tok),
        .res_valid    (res_valid),
        .res_total    (res_total),
        .res_exceeded (res_exceeded),
        .res_taken    (m_axis_tready)
    );

    assign m_axis_tvalid = res_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W - TOTAL_W - 1){1'b0}}, res_exceeded, res_total};

`ifndef SYNTHESIS
    // fill count never passes the row length
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL)
        else $error("fill count beyond capacity");

    // an element taken while full enters the row as a dropped token
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (s_beat && fill_reg == FILL_FULL) |=> (head_reg.vld && head_reg.drop))
        else $error("element past capacity not dropped");

    // a new result only comes from a last-marked token leaving the row
    a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(tail_tok.vld && tail_tok.last && adv))
        else $error("result beat without a last element");

    // after a last element the next array starts empty
    a_fill_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s_beat && s_axis_tlast) |=> (fill_reg == '0))
        else $error("fill count not cleared after last element");
`endif

endmodule

[tb/tb.sv]
// tb: self-checking bench for inversion_counter_unit, arrays streamed in as element beats
// computes the expected pair count for every array and checks each result beat against it
// depends on invc_pkg and inversion_counter_unit

module tb;

    import invc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned DRAIN_WAIT  = MAX_ELEMENTS + 16;

    // how the values of one array are drawn
    typedef enum int {
        VALS_NARROW,
        VALS_WIDE,
        VALS_EDGE
    } value_mix_t;

    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic               over;
    } array_result_t;

    // keeps its own copy of the arrays and the expected result of each one
    class inversion_scoreboard;
        logic signed [VALUE_W-1:0] held_values[MAX_ELEMENTS];
        int unsigned               held_count;
        int unsigned               pair_total;
        bit                        dropped_any;
        array_result_t             expected_q[$];
        int unsigned               errors;

        function new();
            held_count  = 0;
            pair_total  = 0;
            dropped_any = 0;
            errors      = 0;
        endfunction

        // one accepted element beat
        function void note_element(logic signed [VALUE_W-1:0] value, logic last);
            int unsigned   greater;
            array_result_t want;
            if (held_count < MAX_ELEMENTS)
            begin
                greater = pair_total;
                for (int k = 0; k < held_count; k++)
                begin
                    if (held_values[k] > value)
                        greater++;
                end
                pair_total = (greater > TOTAL_MAX) ? TOTAL_MAX : greater;
                held_values[held_count] = value;
                held_count++;
            end
            else
            begin
                // past capacity: dropped, only the flag remembers it
                dropped_any = 1;
            end
            if (last)
            begin
                want.total  = pair_total[TOTAL_W-1:0];
                want.over   = dropped_any;
                expected_q  = {expected_q, want};
                held_count  = 0;
                pair_total  = 0;
                dropped_any = 0;
            end
        endfunction

        // one accepted result beat
        function void check_result(logic [OUT_DATA_W-1:0] beat);
            array_result_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result beat with nothing expected, actual %h", $time, beat);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (beat[TOTAL_W-1:0] !== want.total)
            begin
                $display("%0t: inversion_total expected %0d actual %0d",
                         $time, want.total, beat[TOTAL_W-1:0]);
                errors++;
            end
            if (beat[TOTAL_W] !== want.over)
            begin
                $display("%0t: capacity_exceeded expected %0b actual %0b",
                         $time, want.over, beat[TOTAL_W]);
                errors++;
            end
            if (beat[OUT_DATA_W-1:TOTAL_W+1] !== '0)
            begin
                $display("%0t: pad bits expected 0 actual %h",
                         $time, beat[OUT_DATA_W-1:TOTAL_W+1]);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [31:0]           s_axis_tdata;
    logic                  s_axis_tlast;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    inversion_scoreboard sb;
    bit                  calm;          // set for the closing stretch: no idling on either side
    int unsigned         sink_stall;
    int unsigned         cycle_count;

    inversion_counter_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // sink side: random stall bursts, no new burst once calm
    always @(negedge clk)
    begin
        if (sink_stall > 0)
        begin
            sink_stall    <= sink_stall - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 5) == 0)
        begin
            sink_stall    <= $urandom_range(1, 14) - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    // result beats are taken at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [31:0] pick_value(value_mix_t mix);
        case (mix)
            // narrow range gives plenty of ties and inversions
            VALS_NARROW: return 32'($urandom_range(0, 8)) - 32'd4;
            VALS_WIDE:   return $urandom;
            default:
            begin
                case ($urandom_range(0, 5))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7FFF_FFFF;
                    2:       return 32'h0000_0000;
                    3:       return 32'hFFFF_FFFF;
                    4:       return 32'h0000_0001;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    // one element beat; may idle first, returns at the falling edge after the handshake
    task automatic send_beat(input logic [31:0] value, input logic last);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_element(value, last);
        @(negedge clk);
    endtask

    task automatic send_array(input int unsigned len, input value_mix_t mix);
        for (int unsigned k = 0; k < len; k++)
            send_beat(pick_value(mix), k == len - 1);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int unsigned sent;
        int unsigned len;

        sb            = new();
        calm          = 0;
        sink_stall    = 0;
        cycle_count   = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // single-element array, most negative value
        send_beat(32'h8000_0000, 1'b1);
        // signed extremes both ways round
        send_beat(32'h7FFF_FFFF, 1'b0);
        send_beat(32'h8000_0000, 1'b1);
        send_beat(32'h8000_0000, 1'b0);
        send_beat(32'h7FFF_FFFF, 1'b1);
        // equal values never count
        send_beat(32'd5, 1'b0);
        send_beat(32'd5, 1'b0);
        send_beat(32'd5, 1'b1);
        // -1 is below 0 as a signed value
        send_beat(32'hFFFF_FFFF, 1'b0);
        send_beat(32'h0000_0000, 1'b1);
        send_beat(32'h0000_0000, 1'b0);
        send_beat(32'hFFFF_FFFF, 1'b1);
        // strictly descending
        send_beat(32'd3, 1'b0);
        send_beat(32'd2, 1'b0);
        send_beat(32'd1, 1'b0);
        send_beat(32'd0, 1'b1);
        // alternating bit patterns
        send_beat(32'h5555_5555, 1'b0);
        send_beat(32'hAAAA_AAAA, 1'b1);

        // hold the source until every result is back
        s_axis_tvalid <= 1'b0;
        wait_drained();
        @(negedge clk);

        // mostly short arrays, now and then a longer one
        sent = 0;
        while (sent < 90)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                              : $urandom_range(1, 12);
            send_array(len, value_mix_t'($urandom_range(0, 2)));
            sent += len;
        end

        // full descending row plus one dropped last beat: largest total and the overflow flag
        for (int unsigned k = 0; k < MAX_ELEMENTS + 1; k++)
            send_beat(32'h7FFF_FFFF - k, k == MAX_ELEMENTS);

        // closing stretch with no idling
        calm = 1;
        sent = 0;
        while (sent < 40)
        begin
            len = $urandom_range(1, 10);
            send_array(len, value_mix_t'($urandom_range(0, 2)));
            sent += len;
        end

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);

        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[files.f]
rtl/core/invc_pkg.sv
rtl/core/invc_cell.sv
rtl/core/invc_chain.sv
rtl/core/invc_tail.sv
rtl/core/inversion_counter_unit.sv
tb/tb.sv
